// ===== rtl/core/tcr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared constants, types and helpers of the three-rotor letter cipher.
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam int unsigned ALPHABET_SIZE = 26;
  localparam int unsigned SYM_W = $clog2(ALPHABET_SIZE);

  typedef logic [SYM_W-1:0] sym_t;

  localparam logic CMD_CIPHER = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  localparam logic [1:0] ROTOR_ONE   = 2'd0;
  localparam logic [1:0] ROTOR_TWO   = 2'd1;
  localparam logic [1:0] ROTOR_THREE = 2'd2;

  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

  function automatic sym_t add_mod(sym_t a, sym_t b);
    logic [SYM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SYM_W+1)'(ALPHABET_SIZE)) begin
      s = s - (SYM_W+1)'(ALPHABET_SIZE);
    end
    return s[SYM_W-1:0];
  endfunction

  typedef struct packed {
    logic       letter;
    logic [7:0] ch;
    logic       load_error;
    logic       write_ok;
    logic [1:0] sel;
    sym_t       index;
    sym_t       value;
    sym_t       pos2;
    sym_t       pos3;
  } stage_t;

endpackage

// ===== rtl/core/tcr_if.sv =====
// ----------------------------------------------------------------------------
// tcr_if
// Valid/ready request and result channels of the three-rotor letter cipher.
// ----------------------------------------------------------------------------
interface tcr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_in;
  logic [1:0] rotor_sel;
  logic [4:0] entry_index;
  logic [4:0] entry_value;

  modport source (output valid, command, char_in, rotor_sel, entry_index, entry_value,
                  input ready);
  modport sink (input valid, command, char_in, rotor_sel, entry_index, entry_value,
                output ready);
endinterface

interface tcr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       load_error;

  modport source (output valid, char_out, load_error, input ready);
  modport sink (input valid, char_out, load_error, output ready);
endinterface

// ===== rtl/core/three_rotor_letter_cipher.sv =====
// ----------------------------------------------------------------------------
// three_rotor_letter_cipher
// An accepted request passes the stage-one, stage-two and output registers, each
// reading one of the three rotor memories through its single port. One request
// per cycle is taken while out_o.ready does not stall the pipeline.
// Reset clears the rotor positions and empties the pipeline; the rotor tables
// are not cleared and hold undefined data until they are loaded.
// ----------------------------------------------------------------------------
module three_rotor_letter_cipher (
  input  logic clk_i,
  input  logic rst_ni,
  tcr_in_if.sink     in_i,
  tcr_out_if.source  out_o
);

  tcr_pkg::sym_t rot1_mem [tcr_pkg::ALPHABET_SIZE];
  tcr_pkg::sym_t rot2_mem [tcr_pkg::ALPHABET_SIZE];
  tcr_pkg::sym_t rot3_mem [tcr_pkg::ALPHABET_SIZE];

  tcr_pkg::sym_t r1_q, r2_q, r3_q;
  tcr_pkg::sym_t pos1_q, pos2_q, pos3_q;
  tcr_pkg::sym_t pos1_d, pos2_d, pos3_d;

  tcr_pkg::stage_t s0, s1_q, s2_q;
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_letter_q, out_err_q;
  logic [7:0] out_ch_q;

  logic in_acc, adv1, adv2;
  logic is_upper, is_lower, is_letter;
  logic [7:0] base;
  tcr_pkg::sym_t v0, idx1, idx2, idx3;

  always_comb begin
    is_upper  = in_i.char_in inside {[tcr_pkg::CHAR_UPPER_A:tcr_pkg::CHAR_UPPER_Z]};
    is_lower  = in_i.char_in inside {[tcr_pkg::CHAR_LOWER_A:tcr_pkg::CHAR_LOWER_Z]};
    is_letter = (in_i.command == tcr_pkg::CMD_CIPHER) && (is_upper || is_lower);
    base      = is_upper ? tcr_pkg::CHAR_UPPER_A : tcr_pkg::CHAR_LOWER_A;
    v0        = tcr_pkg::sym_t'(in_i.char_in - base);
    idx1      = tcr_pkg::add_mod(v0, pos1_q);

    s0.letter     = is_letter;
    s0.ch         = (in_i.command == tcr_pkg::CMD_LOAD) ? 8'd0 :
                    (is_letter ? base : in_i.char_in);
    s0.load_error = (in_i.command == tcr_pkg::CMD_LOAD) &&
                    (in_i.entry_value >= 5'(tcr_pkg::ALPHABET_SIZE));
    s0.write_ok   = (in_i.command == tcr_pkg::CMD_LOAD) &&
                    (in_i.entry_value < 5'(tcr_pkg::ALPHABET_SIZE)) &&
                    (in_i.entry_index < 5'(tcr_pkg::ALPHABET_SIZE)) &&
                    (in_i.rotor_sel == tcr_pkg::ROTOR_ONE ||
                     in_i.rotor_sel == tcr_pkg::ROTOR_TWO ||
                     in_i.rotor_sel == tcr_pkg::ROTOR_THREE);
    s0.sel        = in_i.rotor_sel;
    s0.index      = in_i.entry_index;
    s0.value      = in_i.entry_value;
    s0.pos2       = pos2_q;
    s0.pos3       = pos3_q;
  end

  assign idx2 = tcr_pkg::add_mod(r1_q, s1_q.pos2);
  assign idx3 = tcr_pkg::add_mod(r2_q, s2_q.pos3);

  assign adv2       = s2_v_q && (!out_v_q || out_o.ready);
  assign adv1       = s1_v_q && (!s2_v_q || adv2);
  assign in_i.ready = !s1_v_q || adv1;
  assign in_acc     = in_i.valid && in_i.ready;

  // Each rotor is written and read by the same stage, so accesses stay in order.
  always_ff @(posedge clk_i) begin
    if (in_acc && s0.write_ok && s0.sel == tcr_pkg::ROTOR_ONE) begin
      rot1_mem[s0.index] <= s0.value;
    end
    if (in_acc && s0.letter) begin
      r1_q <= rot1_mem[idx1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && s1_q.write_ok && s1_q.sel == tcr_pkg::ROTOR_TWO) begin
      rot2_mem[s1_q.index] <= s1_q.value;
    end
    if (adv1 && s1_q.letter) begin
      r2_q <= rot2_mem[idx2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s2_q.write_ok && s2_q.sel == tcr_pkg::ROTOR_THREE) begin
      rot3_mem[s2_q.index] <= s2_q.value;
    end
    if (adv2 && s2_q.letter) begin
      r3_q <= rot3_mem[idx3];
    end
  end

  always_comb begin
    pos1_d = pos1_q;
    pos2_d = pos2_q;
    pos3_d = pos3_q;
    if (in_acc && s0.write_ok) begin
      pos1_d = '0;
      pos2_d = '0;
      pos3_d = '0;
    end else if (in_acc && s0.letter) begin
      if (pos1_q == tcr_pkg::sym_t'(tcr_pkg::ALPHABET_SIZE - 1)) begin
        pos1_d = '0;
        if (pos2_q == tcr_pkg::sym_t'(tcr_pkg::ALPHABET_SIZE - 1)) begin
          pos2_d = '0;
          if (pos3_q == tcr_pkg::sym_t'(tcr_pkg::ALPHABET_SIZE - 1)) begin
            pos3_d = '0;
          end else begin
            pos3_d = pos3_q + 1'b1;
          end
        end else begin
          pos2_d = pos2_q + 1'b1;
        end
      end else begin
        pos1_d = pos1_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos1_q  <= '0;
      pos2_q  <= '0;
      pos3_q  <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      pos1_q <= pos1_d;
      pos2_q <= pos2_d;
      pos3_q <= pos3_d;
      if (in_i.ready) begin
        s1_v_q <= in_i.valid;
      end
      if (!s2_v_q || adv2) begin
        s2_v_q <= adv1;
      end
      if (!out_v_q || out_o.ready) begin
        out_v_q <= adv2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s0;
    end
    if (adv1) begin
      s2_q <= s1_q;
    end
    if (adv2) begin
      out_letter_q <= s2_q.letter;
      out_ch_q     <= s2_q.ch;
      out_err_q    <= s2_q.load_error;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.char_out   = out_ch_q + (out_letter_q ? 8'(r3_q) : 8'd0);
  assign out_o.load_error = out_err_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos1_q < tcr_pkg::sym_t'(tcr_pkg::ALPHABET_SIZE) &&
    pos2_q < tcr_pkg::sym_t'(tcr_pkg::ALPHABET_SIZE) &&
    pos3_q < tcr_pkg::sym_t'(tcr_pkg::ALPHABET_SIZE))
    else $error("rotor position out of range");

  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s0.write_ok) |=> (pos1_q == '0 && pos2_q == '0 && pos3_q == '0))
    else $error("good load did not clear the rotor positions");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s0.letter && pos1_q != tcr_pkg::sym_t'(tcr_pkg::ALPHABET_SIZE - 1))
    |=> (pos1_q == $past(pos1_q) + 1'b1 && $stable(pos2_q) && $stable(pos3_q)))
    else $error("rotor position did not step after a letter");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.load_error) |-> (out_o.char_out == 8'd0))
    else $error("rejected load returned a nonzero character");

endmodule

// ===== tb/sv/three_rotor_letter_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// three_rotor_letter_cipher_tb
// Self-checking testbench of the three-rotor letter cipher. Requests are sent
// through the input channel and mirrored into a local rotor machine. That
// machine keeps its own tables and positions, and its predicted characters are
// compared in order with the output channel. Both channels idle and stall at
// random. The tests cover pass-through bytes, table loads, rejected loads,
// letter extremes, position carries and a long random mix.
// ----------------------------------------------------------------------------
module three_rotor_letter_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_PCT      = 18;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned CARRY_LETTERS  = 2 * tcr_pkg::ALPHABET_SIZE + 10;
  localparam int unsigned RANDOM_ITEMS   = 585;
  localparam int unsigned STEADY_FIRST   = 200;
  localparam int unsigned STEADY_LAST    = 400;

  localparam logic [1:0] ROTOR_NONE = 2'd3;

  typedef struct packed {
    logic       command;
    logic [7:0] ch;
    logic [1:0] sel;
    logic [4:0] index;
    logic [4:0] value;
  } cipher_req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       load_error;
  } cipher_rsp_t;

  logic clk_i;
  logic rst_ni;

  tcr_in_if  in_if ();
  tcr_out_if out_if ();

  three_rotor_letter_cipher u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  tcr_pkg::sym_t rotor_tab [3][tcr_pkg::ALPHABET_SIZE];
  tcr_pkg::sym_t rot_pos [3];
  cipher_rsp_t   awaited_chars_q [$];
  int            mismatches;
  bit            no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_letter(logic [7:0] c);
    return (c >= tcr_pkg::CHAR_UPPER_A && c <= tcr_pkg::CHAR_UPPER_Z) ||
           (c >= tcr_pkg::CHAR_LOWER_A && c <= tcr_pkg::CHAR_LOWER_Z);
  endfunction

  function automatic cipher_rsp_t cipher_predict(cipher_req_t r);
    cipher_rsp_t   rsp;
    logic [7:0]    base;
    tcr_pkg::sym_t sym;
    rsp.char_out   = 8'h00;
    rsp.load_error = 1'b0;
    if (r.command == tcr_pkg::CMD_LOAD) begin
      if (r.value >= tcr_pkg::ALPHABET_SIZE) begin
        rsp.load_error = 1'b1;
      end else if (r.sel <= tcr_pkg::ROTOR_THREE && r.index < tcr_pkg::ALPHABET_SIZE) begin
        rotor_tab[r.sel][r.index] = r.value;
        foreach (rot_pos[k]) rot_pos[k] = '0;
      end
    end else if (is_letter(r.ch)) begin
      base = (r.ch <= tcr_pkg::CHAR_UPPER_Z) ? tcr_pkg::CHAR_UPPER_A : tcr_pkg::CHAR_LOWER_A;
      sym  = tcr_pkg::sym_t'(r.ch - base);
      for (int k = 0; k < 3; k++) begin
        sym = rotor_tab[k][(sym + rot_pos[k]) % tcr_pkg::ALPHABET_SIZE];
      end
      rsp.char_out = base + 8'(sym);
      for (int k = 0; k < 3; k++) begin
        if (rot_pos[k] == tcr_pkg::sym_t'(tcr_pkg::ALPHABET_SIZE - 1)) begin
          rot_pos[k] = '0;
        end else begin
          rot_pos[k] = rot_pos[k] + 1'b1;
          break;
        end
      end
    end else begin
      rsp.char_out = r.ch;
    end
    return rsp;
  endfunction

  function automatic cipher_req_t random_fields();
    cipher_req_t r;
    r.command = tcr_pkg::CMD_CIPHER;
    r.ch      = 8'($urandom);
    r.sel     = 2'($urandom);
    r.index   = 5'($urandom);
    r.value   = 5'($urandom);
    return r;
  endfunction

  function automatic logic [7:0] random_letter();
    return ($urandom_range(1) ? tcr_pkg::CHAR_UPPER_A : tcr_pkg::CHAR_LOWER_A) +
           8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] random_non_letter();
    logic [7:0] c;
    do c = 8'($urandom); while (is_letter(c));
    return c;
  endfunction

  task automatic send_request(cipher_req_t r);
    while (!no_idle && $urandom_range(99) < STALL_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= r.command;
    in_if.char_in     <= r.ch;
    in_if.rotor_sel   <= r.sel;
    in_if.entry_index <= r.index;
    in_if.entry_value <= r.value;
    do @(posedge clk_i); while (!in_if.ready);
    awaited_chars_q.push_back(cipher_predict(r));
  endtask

  task automatic send_char(logic [7:0] c);
    cipher_req_t r;
    r    = random_fields();
    r.ch = c;
    send_request(r);
  endtask

  task automatic send_load(logic [1:0] sel, logic [4:0] idx, logic [4:0] val);
    cipher_req_t r;
    r         = random_fields();
    r.command = tcr_pkg::CMD_LOAD;
    r.sel     = sel;
    r.index   = idx;
    r.value   = val;
    send_request(r);
  endtask

  task automatic test_passthrough();
    logic [7:0] bytes [8];
    bytes = '{8'd0, 8'd64, 8'd91, 8'd96, 8'd123, 8'd127, 8'd128, 8'd255};
    foreach (bytes[i]) send_char(bytes[i]);
  endtask

  // Every entry is written before the first letter, so no lookup hits an
  // entry that was never loaded.
  task automatic test_table_fill();
    logic [4:0] val;
    for (int s = 0; s <= tcr_pkg::ROTOR_THREE; s++) begin
      for (int i = 0; i < tcr_pkg::ALPHABET_SIZE; i++) begin
        if (i == 0) val = 5'd0;
        else if (i == tcr_pkg::ALPHABET_SIZE - 1) val = 5'(tcr_pkg::ALPHABET_SIZE - 1);
        else val = 5'($urandom_range(tcr_pkg::ALPHABET_SIZE - 1));
        send_load(2'(s), 5'(i), val);
      end
    end
  endtask

  task automatic test_letter_bounds();
    send_char(tcr_pkg::CHAR_UPPER_A);
    send_char(tcr_pkg::CHAR_UPPER_Z);
    send_char(tcr_pkg::CHAR_LOWER_A);
    send_char(tcr_pkg::CHAR_LOWER_Z);
    send_char(8'd77);
    send_char(8'd113);
  endtask

  task automatic test_load_errors();
    send_load(tcr_pkg::ROTOR_ONE, 5'd3, 5'd31);
    send_char(tcr_pkg::CHAR_UPPER_A);
    send_load(ROTOR_NONE, 5'd4, 5'd7);
    send_char(tcr_pkg::CHAR_LOWER_Z);
    send_load(tcr_pkg::ROTOR_TWO, 5'd31, 5'd9);
    send_load(tcr_pkg::ROTOR_THREE, 5'd26, 5'd30);
    send_load(ROTOR_NONE, 5'd0, 5'd26);
    send_char(tcr_pkg::CHAR_LOWER_A);
    send_load(tcr_pkg::ROTOR_TWO, 5'd17, 5'd16);
    send_char(tcr_pkg::CHAR_UPPER_Z);
  endtask

  // Long enough for position one to wrap twice and carry into position two.
  task automatic test_rotor_carry();
    send_load(tcr_pkg::ROTOR_ONE, 5'd0, rotor_tab[tcr_pkg::ROTOR_ONE][0]);
    repeat (CARRY_LETTERS) send_char(random_letter());
  endtask

  task automatic test_random_mix();
    int unsigned pick;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= STEADY_FIRST && n < STEADY_LAST);
      pick    = $urandom_range(99);
      if (pick < 65) begin
        send_char(random_letter());
      end else if (pick < 80) begin
        send_char(random_non_letter());
      end else if (pick < 95) begin
        send_load(2'($urandom_range(tcr_pkg::ROTOR_THREE)),
                  5'($urandom_range(tcr_pkg::ALPHABET_SIZE - 1)),
                  5'($urandom_range(tcr_pkg::ALPHABET_SIZE - 1)));
      end else begin
        case ($urandom_range(2))
          0: send_load(2'($urandom), 5'($urandom),
                       5'($urandom_range(31, tcr_pkg::ALPHABET_SIZE)));
          1: send_load(ROTOR_NONE, 5'($urandom), 5'($urandom));
          default: send_load(2'($urandom), 5'($urandom_range(31, tcr_pkg::ALPHABET_SIZE)),
                             5'($urandom));
        endcase
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk_i) begin : result_check
    cipher_rsp_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_chars_q.size() == 0) begin
        $display("%0t: unexpected result char_out 0x%02h load_error %0b",
                 $time, out_if.char_out, out_if.load_error);
        mismatches++;
      end else begin
        want = awaited_chars_q.pop_front();
        if (out_if.char_out !== want.char_out) begin
          $display("%0t: char_out expected 0x%02h actual 0x%02h",
                   $time, want.char_out, out_if.char_out);
          mismatches++;
        end
        if (out_if.load_error !== want.load_error) begin
          $display("%0t: load_error expected %0b actual %0b",
                   $time, want.load_error, out_if.load_error);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stuck = 0;
      else stuck++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    mismatches = 0;
    no_idle    = 1'b0;
    foreach (rot_pos[k]) rot_pos[k] = '0;
    rst_ni             = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.command     <= tcr_pkg::CMD_CIPHER;
    in_if.char_in     <= 8'h00;
    in_if.rotor_sel   <= tcr_pkg::ROTOR_ONE;
    in_if.entry_index <= 5'd0;
    in_if.entry_value <= 5'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough();
    test_table_fill();
    test_letter_bounds();
    test_load_errors();
    test_rotor_carry();
    test_random_mix();

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_chars_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
